// ===== design/slt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the server locator table.
// ----------------------------------------------------------------------------
package slt_pkg;
  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_SERVERS = 16;
  localparam int EW = $clog2(TABLE_ENTRIES);
  localparam int SW = $clog2(MAX_SERVERS);

  typedef enum logic [1:0] {
    OP_REG  = 2'd0,
    OP_LOOK = 2'd1,
    OP_GONE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFUNC  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REGPOS,
    S_REGDEL,
    S_SCAN,
    S_SCAN_WAIT,
    S_RECPOS,
    S_APPEND,
    S_LOC,
    S_LOC_WAIT,
    S_RECFIND,
    S_RECDEL,
    S_MARK,
    S_COMPACT,
    S_COMPACT_WAIT,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== design/service_locator_lru_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// service_locator_lru_table_top
// Ordered server/function table with least recently used server choice.
//
// s_axis carries one request: func, server_id, func_key, server_location.
// m_axis carries one reply per request: status, found_location,
// chosen_server, servers_registered.
// One request is taken at a time; s_axis_tready is low while it is worked
// and while a reply waits. One comparator walks the server lists one slot a
// cycle; the entry table has one read port, and each entry that it reads is
// registered before it is compared. A lookup walks the recency list for
// each entry whose key matches; an unused code goes straight to the reply.
// Reset empties the table and both server lists at once; no clearing pass.
// A stalled reply holds in the output register; the next request is taken
// the cycle after it is transferred.
// ----------------------------------------------------------------------------
module service_locator_lru_table_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // func[1:0], server_id[11:2], func_key[43:12], server_location[91:44]
  input  wire logic [95:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], found_location[49:2], chosen_server[59:50],
  // servers_registered[64:60]
  output logic [71:0]       m_axis_tdata
);
  import slt_pkg::*;

  state_t state, state_next;
  op_t         in_op;
  op_t         op;
  status_t     status;
  logic [9:0]  srv;
  logic [31:0] key;
  logic [47:0] loc;
  logic [9:0]  probe;

  logic [9:0]  e_srv [TABLE_ENTRIES];
  logic [31:0] e_key [TABLE_ENTRIES];
  logic [47:0] e_loc [TABLE_ENTRIES];
  logic [EW:0] e_cnt;
  logic [9:0]  rd_srv;
  logic [31:0] rd_key;
  logic [47:0] rd_loc;

  logic [9:0]  rec [MAX_SERVERS];
  logic [SW:0] rec_cnt;
  logic [9:0]  regl [MAX_SERVERS];
  logic [SW:0] reg_cnt;

  logic [EW:0]   i, w;
  logic [SW:0]   j, j_inc;
  logic          found_reg;
  logic [SW:0]   best_pos;
  logic [EW-1:0] best;
  logic          best_ok;
  logic          rd_en, wr_en;
  logic [EW-1:0] rd_addr, wr_addr;
  logic [9:0]    wr_srv;
  logic [31:0]   wr_key;
  logic [47:0]   wr_loc;
  logic [9:0]    list_val;
  logic          hit;
  logic [47:0]   out_loc;
  logic [9:0]    out_srv;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign in_op = op_t'(s_axis_tdata[1:0]);
  assign j_inc = j + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          case (in_op)
            OP_REG, OP_GONE: state_next = S_REGPOS;
            OP_LOOK: state_next = S_SCAN;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_REGPOS: begin
        if (!found_reg && j < reg_cnt) state_next = S_REGPOS;
        else if (op == OP_GONE) state_next = found_reg ? S_REGDEL : S_OUT;
        else if (!found_reg && reg_cnt >= (SW+1)'(MAX_SERVERS)) state_next = S_OUT;
        else state_next = S_SCAN;
      end
      S_REGDEL: if (j_inc >= reg_cnt) state_next = S_RECFIND;
      S_SCAN: begin
        if (i < e_cnt) state_next = S_SCAN_WAIT;
        else if (op == OP_REG) state_next = S_APPEND;
        else if (best_ok) state_next = S_LOC;
        else state_next = S_OUT;
      end
      S_SCAN_WAIT: begin
        if (op == OP_REG) state_next = (rd_srv == srv && rd_key == key) ? S_OUT : S_SCAN;
        else state_next = (rd_key == key) ? S_RECPOS : S_SCAN;
      end
      S_RECPOS: begin
        if (j < rec_cnt) begin
          if (hit) state_next = S_SCAN;
        end else begin
          state_next = S_LOC;
        end
      end
      S_APPEND: state_next = S_OUT;
      S_LOC: state_next = S_LOC_WAIT;
      S_LOC_WAIT: state_next = S_RECFIND;
      S_RECFIND: begin
        if (j < rec_cnt) begin
          if (hit) state_next = S_RECDEL;
        end else if (op == OP_LOOK) begin
          state_next = (rec_cnt >= (SW+1)'(MAX_SERVERS)) ? S_RECDEL : S_MARK;
        end else begin
          state_next = S_COMPACT;
        end
      end
      S_RECDEL: begin
        if (j_inc >= rec_cnt) state_next = (op == OP_LOOK) ? S_MARK : S_COMPACT;
      end
      S_MARK: state_next = S_OUT;
      S_COMPACT: state_next = (i < e_cnt) ? S_COMPACT_WAIT : S_OUT;
      S_COMPACT_WAIT: state_next = S_COMPACT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    list_val = (state == S_REGPOS) ? regl[j[SW-1:0]] : rec[j[SW-1:0]];
    hit = (list_val == probe);
    rd_en = ((state == S_SCAN || state == S_COMPACT) && i < e_cnt) || state == S_LOC;
    rd_addr = (state == S_LOC) ? best : i[EW-1:0];
    wr_en = (state == S_APPEND && e_cnt < (EW+1)'(TABLE_ENTRIES))
      || (state == S_COMPACT_WAIT && rd_srv != srv);
    if (state == S_APPEND) begin
      wr_addr = e_cnt[EW-1:0];
      wr_srv = srv;
      wr_key = key;
      wr_loc = loc;
    end else begin
      wr_addr = w[EW-1:0];
      wr_srv = rd_srv;
      wr_key = rd_key;
      wr_loc = rd_loc;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_srv <= e_srv[rd_addr];
      rd_key <= e_key[rd_addr];
      rd_loc <= e_loc[rd_addr];
    end
    if (wr_en) begin
      e_srv[wr_addr] <= wr_srv;
      e_key[wr_addr] <= wr_key;
      e_loc[wr_addr] <= wr_loc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      e_cnt <= '0;
      rec_cnt <= '0;
      reg_cnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op <= in_op;
            srv <= s_axis_tdata[11:2];
            probe <= s_axis_tdata[11:2];
            key <= s_axis_tdata[43:12];
            loc <= s_axis_tdata[91:44];
            i <= '0;
            w <= '0;
            j <= '0;
            found_reg <= 1'b0;
            best_ok <= 1'b0;
            best <= '0;
            best_pos <= rec_cnt;
            status <= ST_DONE;
            out_loc <= '0;
            out_srv <= '0;
          end
        end
        S_REGPOS: begin
          if (!found_reg && j < reg_cnt) begin
            if (hit) found_reg <= 1'b1;
            else j <= j_inc;
          end else if (op == OP_REG && !found_reg) begin
            if (reg_cnt >= (SW+1)'(MAX_SERVERS)) begin
              status <= ST_FULL;
            end else begin
              regl[reg_cnt[SW-1:0]] <= srv;
              reg_cnt <= reg_cnt + 1'b1;
            end
          end
        end
        S_REGDEL: begin
          if (j_inc < reg_cnt) begin
            regl[j[SW-1:0]] <= regl[j_inc[SW-1:0]];
            j <= j_inc;
          end else begin
            reg_cnt <= reg_cnt - 1'b1;
            j <= '0;
          end
        end
        S_SCAN: begin
          if (i >= e_cnt && op == OP_LOOK && !best_ok) status <= ST_NOFUNC;
        end
        S_SCAN_WAIT: begin
          if (op == OP_REG) begin
            if (rd_srv == srv && rd_key == key) status <= ST_PRESENT;
            else i <= i + 1'b1;
          end else if (rd_key == key) begin
            probe <= rd_srv;
            j <= '0;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_RECPOS: begin
          if (j < rec_cnt) begin
            if (hit) begin
              if (j < best_pos) begin
                best_pos <= j;
                best <= i[EW-1:0];
                best_ok <= 1'b1;
              end
              i <= i + 1'b1;
            end else begin
              j <= j_inc;
            end
          end else begin
            // server never ran: take this entry and stop
            best <= i[EW-1:0];
            best_ok <= 1'b1;
          end
        end
        S_APPEND: begin
          if (e_cnt >= (EW+1)'(TABLE_ENTRIES)) status <= ST_FULL;
          else e_cnt <= e_cnt + 1'b1;
        end
        S_LOC_WAIT: begin
          out_loc <= rd_loc;
          out_srv <= rd_srv;
          probe <= rd_srv;
          j <= '0;
        end
        S_RECFIND: begin
          if (j < rec_cnt) begin
            if (!hit) j <= j_inc;
          end else begin
            // server not listed; on a lookup with the list full, drop the oldest record
            j <= '0;
          end
        end
        S_RECDEL: begin
          if (j_inc < rec_cnt) begin
            rec[j[SW-1:0]] <= rec[j_inc[SW-1:0]];
            j <= j_inc;
          end else begin
            rec_cnt <= rec_cnt - 1'b1;
          end
        end
        S_MARK: begin
          rec[rec_cnt[SW-1:0]] <= probe;
          rec_cnt <= rec_cnt + 1'b1;
        end
        S_COMPACT: begin
          if (i >= e_cnt) e_cnt <= w;
        end
        S_COMPACT_WAIT: begin
          if (rd_srv != srv) w <= w + 1'b1;
          i <= i + 1'b1;
        end
        S_OUT: begin
          m_axis_tdata <= {7'd0, reg_cnt, out_srv, out_loc, status};
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    e_cnt <= (EW+1)'(TABLE_ENTRIES)) else $error("entry count overflow");
  a_rec_le_reg: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> rec_cnt <= reg_cnt) else $error("recency exceeds servers");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("reply changed while stalled");
`endif
endmodule
`default_nettype wire
